// ===== design/join_statement_lexer_macros.svh =====
// ---------------------------------------------------------------------------
// join_statement_lexer_macros.svh
// Assertion macros used by the statement lexer checker.
// ---------------------------------------------------------------------------
`ifndef JOIN_STATEMENT_LEXER_MACROS_SVH
`define JOIN_STATEMENT_LEXER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSL_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/jsl_pkg.sv =====
// ---------------------------------------------------------------------------
// jsl_pkg
// Types and constants of the statement lexer.
// ---------------------------------------------------------------------------
`default_nettype none

package jsl_pkg;

  localparam int JSL_COUNT_WIDTH = 16;
  localparam int JSL_OUT_WIDTH   = 16;
  localparam int JSL_QUEUE_DEPTH = 4;

  // byte classes produced by the front end
  typedef enum logic [2:0] {
    CLS_SEP,
    CLS_NAME,
    CLS_BLANK,
    CLS_PLUS,
    CLS_EQ,
    CLS_HASH,
    CLS_OTHER
  } cls_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_OPER,
    PH_AFTER_OPER,
    PH_NEED_OPER,
    PH_NEED_LABEL,
    PH_LABEL,
    PH_AFTER_LABEL,
    PH_COMMENT,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_BLANK,
    ROLE_OPERAND,
    ROLE_LABEL,
    ROLE_OPER,
    ROLE_COMMENT,
    ROLE_SEP
  } role_t;

  typedef enum logic [2:0] {
    ST_BLANK,
    ST_OK,
    ST_NAME,
    ST_LABEL,
    ST_CHAR
  } status_t;

  typedef struct packed {
    cls_t cls;
    logic last;
  } item_t;

  typedef struct packed {
    logic [JSL_OUT_WIDTH-1:0] errors;
    logic [JSL_OUT_WIDTH-1:0] index;
    logic                     label_present;
    logic [JSL_OUT_WIDTH-1:0] operands;
    status_t                  status;
    logic                     token_start;
    role_t                    role;
  } result_t;

endpackage

`default_nettype wire

// ===== design/jsl_front.sv =====
// ---------------------------------------------------------------------------
// jsl_front
// Byte intake: classifies each byte and pushes it to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module jsl_front (
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,
  input  wire logic         s_tlast,
  input  wire logic         separator_mode,
  input  wire logic         q_full,
  output logic              push,
  output jsl_pkg::item_t    item
);
  import jsl_pkg::*;

  logic is_name;
  logic is_sep;

  always_comb begin
    is_name = (s_tdata >= 8'h61 && s_tdata <= 8'h7a) ||
              (s_tdata >= 8'h41 && s_tdata <= 8'h5a) ||
              (s_tdata >= 8'h30 && s_tdata <= 8'h39) ||
              s_tdata == 8'h5f || s_tdata == 8'h2d;
    is_sep  = separator_mode ? (s_tdata == 8'h2c || s_tdata == 8'h3b)
                             : (s_tdata == 8'h0a);
  end

  always_comb begin
    priority if (is_sep) begin
      item.cls = CLS_SEP;
    end else if (is_name) begin
      item.cls = CLS_NAME;
    end else if (s_tdata == 8'h20 || s_tdata == 8'h09 || s_tdata == 8'h0d) begin
      item.cls = CLS_BLANK;
    end else if (s_tdata == 8'h2b) begin
      item.cls = CLS_PLUS;
    end else if (s_tdata == 8'h3d) begin
      item.cls = CLS_EQ;
    end else if (s_tdata == 8'h23) begin
      item.cls = CLS_HASH;
    end else begin
      item.cls = CLS_OTHER;
    end
    item.last = s_tlast;
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

endmodule

`default_nettype wire

// ===== design/jsl_queue.sv =====
// ---------------------------------------------------------------------------
// jsl_queue
// Small FIFO of classified bytes between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module jsl_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire jsl_pkg::item_t push_item,
  input  wire logic           pop,
  output jsl_pkg::item_t      head,
  output logic                full,
  output logic                empty
);
  import jsl_pkg::*;

  localparam int AW = $clog2(JSL_QUEUE_DEPTH);

  item_t          slots [JSL_QUEUE_DEPTH];
  logic [AW:0]    wr_ptr;
  logic [AW:0]    rd_ptr;
  logic [AW:0]    fill;

  assign fill  = wr_ptr - rd_ptr;
  assign full  = (fill == (AW+1)'(JSL_QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[AW-1:0]] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/jsl_back.sv =====
// ---------------------------------------------------------------------------
// jsl_back
// Statement parser: phase machine, tallies and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module jsl_back #(
  parameter int COUNT_WIDTH = jsl_pkg::JSL_COUNT_WIDTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire jsl_pkg::item_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic                m_tlast,
  output jsl_pkg::result_t    result
);
  import jsl_pkg::*;

  phase_t                 phase, phase_next, phase_adv, ph_eff;
  logic [COUNT_WIDTH-1:0] tally, tally_next, tally_adv;
  logic                   label, label_next, label_adv;
  status_t                perr, perr_next, perr_adv;
  logic [COUNT_WIDTH-1:0] stmt_cnt, stmt_cnt_next;
  logic [COUNT_WIDTH-1:0] err_cnt, err_cnt_next, err_cnt_inc;
  role_t                  role;
  logic                   tok_start;
  logic                   resolved;
  logic                   fallback;
  logic                   done;
  status_t                status;
  result_t                res_next;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign pop = !empty && (!m_tvalid || m_tready);

  // advance over one byte: role, token start and phase after the byte
  always_comb begin
    phase_adv = phase;
    tally_adv = tally;
    label_adv = label;
    perr_adv  = perr;
    role      = ROLE_BLANK;
    tok_start = 1'b0;
    ph_eff    = phase;
    resolved  = 1'b0;
    fallback  = 1'b0;
    if (head.cls == CLS_SEP) begin
      role = ROLE_SEP;
    end else if (phase == PH_COMMENT || phase == PH_ERROR) begin
      role = ROLE_COMMENT;
    end else begin
      if (phase == PH_OPER || phase == PH_LABEL) begin
        if (head.cls == CLS_NAME) begin
          role     = (phase == PH_OPER) ? ROLE_OPERAND : ROLE_LABEL;
          resolved = 1'b1;
        end else begin
          ph_eff = (phase == PH_OPER) ? PH_AFTER_OPER : PH_AFTER_LABEL;
          if (head.cls == CLS_BLANK) begin
            phase_adv = ph_eff;
            resolved  = 1'b1;
          end
        end
      end
      if (!resolved && head.cls != CLS_BLANK) begin
        unique case (ph_eff)
          PH_START, PH_NEED_OPER: begin
            if (head.cls == CLS_NAME) begin
              tok_start = 1'b1;
              tally_adv = sat_inc(tally);
              phase_adv = PH_OPER;
              role      = ROLE_OPERAND;
            end else if (head.cls == CLS_HASH && ph_eff == PH_START) begin
              phase_adv = PH_COMMENT;
              role      = ROLE_COMMENT;
            end else begin
              phase_adv = PH_ERROR;
              perr_adv  = ST_NAME;
              role      = ROLE_COMMENT;
            end
          end
          PH_NEED_LABEL: begin
            if (head.cls == CLS_NAME) begin
              tok_start = 1'b1;
              label_adv = 1'b1;
              phase_adv = PH_LABEL;
              role      = ROLE_LABEL;
            end else begin
              phase_adv = PH_ERROR;
              perr_adv  = ST_LABEL;
              role      = ROLE_COMMENT;
            end
          end
          PH_AFTER_OPER: begin
            if (head.cls == CLS_PLUS) begin
              phase_adv = PH_NEED_OPER;
              role      = ROLE_OPER;
            end else if (head.cls == CLS_EQ) begin
              phase_adv = PH_NEED_LABEL;
              role      = ROLE_OPER;
            end else begin
              fallback = 1'b1;
            end
          end
          default: begin
            fallback = 1'b1;
          end
        endcase
        if (fallback) begin
          role = ROLE_COMMENT;
          if (head.cls == CLS_HASH) begin
            phase_adv = PH_COMMENT;
          end else begin
            phase_adv = PH_ERROR;
            perr_adv  = ST_CHAR;
          end
        end
      end
    end
  end

  // statement end: status, result and next state
  always_comb begin
    done = (head.cls == CLS_SEP) || head.last;
    unique case (phase_adv)
      PH_START:      status = ST_BLANK;
      PH_NEED_OPER:  status = ST_NAME;
      PH_NEED_LABEL: status = ST_LABEL;
      PH_COMMENT:    status = (tally_adv != '0) ? ST_OK : ST_BLANK;
      PH_ERROR:      status = perr_adv;
      default:       status = ST_OK;
    endcase
    err_cnt_inc = (status == ST_NAME || status == ST_LABEL || status == ST_CHAR)
                  ? sat_inc(err_cnt) : err_cnt;

    res_next             = '0;
    res_next.role        = role;
    res_next.token_start = tok_start;
    if (done) begin
      res_next.status        = status;
      res_next.operands      = JSL_OUT_WIDTH'(tally_adv);
      res_next.label_present = (status == ST_OK) ? label_adv : 1'b0;
      res_next.index         = JSL_OUT_WIDTH'(stmt_cnt);
      res_next.errors        = JSL_OUT_WIDTH'(err_cnt_inc);
    end

    if (done) begin
      phase_next    = PH_START;
      tally_next    = '0;
      label_next    = 1'b0;
      perr_next     = ST_BLANK;
      stmt_cnt_next = head.last ? COUNT_WIDTH'(1) : sat_inc(stmt_cnt);
      err_cnt_next  = head.last ? '0 : err_cnt_inc;
    end else begin
      phase_next    = phase_adv;
      tally_next    = tally_adv;
      label_next    = label_adv;
      perr_next     = perr_adv;
      stmt_cnt_next = stmt_cnt;
      err_cnt_next  = err_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      tally    <= '0;
      label    <= 1'b0;
      perr     <= ST_BLANK;
      stmt_cnt <= COUNT_WIDTH'(1);
      err_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        phase    <= phase_next;
        tally    <= tally_next;
        label    <= label_next;
        perr     <= perr_next;
        stmt_cnt <= stmt_cnt_next;
        err_cnt  <= err_cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result  <= res_next;
      m_tlast <= done;
    end
  end

endmodule

`default_nettype wire

// ===== design/join_statement_lexer.sv =====
// ---------------------------------------------------------------------------
// join_statement_lexer
// Streaming checker for "name + name ... [= label] [# comment]" statements.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one text byte per transaction in s_tdata[7:0];
//   s_tlast flags the final byte of a text and closes any open statement.
//   Output stream (m_*): one result per input byte, in order. m_tlast is
//   high when a statement ends at that byte; the status, operand count,
//   label flag, statement number and error count are then valid, else 0.
//   Config channel (cfg_*): separator mode, 0 = newline, 1 = ',' or ';'.
//   Always ready; write only while the block is drained. Applies from the
//   next accepted byte.
// Timing: an accepted byte is written into the queue, then parsed from the
//   queue head into the result register. Sustained rate is one byte per
//   cycle while the output is not stalled, set by the phase update in the back end.
// Stall: the front end keeps accepting into a 4-entry queue while the
//   result register waits; s_tready drops only when that queue is full.
// Reset (rst, synchronous): queue emptied, output invalid, phase at start
//   of statement, statement number 1, error count 0, mode 0.
// ---------------------------------------------------------------------------
`default_nettype none

module join_statement_lexer #(
  parameter int COUNT_WIDTH = jsl_pkg::JSL_COUNT_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: [7:0] char_in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,   // last_char
  // m_tdata: [2:0] char_role, [3] token_start, [6:4] statement_status,
  //   [22:7] operands_seen, [23] label_present, [39:24] statement_index,
  //   [55:40] errors_total
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,
  output logic             m_tlast,   // statement_done
  // configuration: separator_mode
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data
);
  import jsl_pkg::*;

  logic    separator_mode;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  item_t   push_item;
  item_t   head;
  result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_mode <= 1'b0;
    end else if (cfg_valid) begin
      separator_mode <= cfg_data[0];
    end
  end

  // front: classify and enqueue
  jsl_front u_front (
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .separator_mode (separator_mode),
    .q_full         (q_full),
    .push           (push),
    .item           (push_item)
  );

  jsl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: parse and register the result
  jsl_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .result   (result)
  );

  assign m_tdata = {result.errors, result.index, result.label_present,
                    result.operands, result.status, result.token_start,
                    result.role};

endmodule

`default_nettype wire

// ===== design/jsl_checker.sv =====
// ---------------------------------------------------------------------------
// jsl_checker
// Port-level checks of the statement lexer output stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "join_statement_lexer_macros.svh"

module jsl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        m_tlast
);
  import jsl_pkg::*;

  `JSL_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
  `JSL_ASSERT_NOW(a_mid_zero, clk, rst, m_tvalid && !m_tlast, m_tdata[55:4] == '0, "status fields set mid statement")
  `JSL_ASSERT_NOW(a_label_ok, clk, rst, m_tvalid && m_tdata[23], m_tdata[6:4] == ST_OK, "label flag on rejected statement")
  `JSL_ASSERT_NOW(a_tok_role, clk, rst, m_tvalid && m_tdata[3], m_tdata[2:0] == ROLE_OPERAND || m_tdata[2:0] == ROLE_LABEL, "token start on non-name byte")
  `JSL_ASSERT_NOW(a_sep_end, clk, rst, m_tvalid && m_tdata[2:0] == ROLE_SEP, m_tlast && m_tdata[39:24] != '0, "separator without statement end")

endmodule

bind join_statement_lexer jsl_checker u_jsl_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_join_statement_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_join_statement_lexer
// Self-checking bench for the statement lexer: byte stream in, one verdict per byte out.
// Each accepted byte is run through a local model of the lexer and the
// predicted verdict is queued. Every output transaction is compared field by
// field with the oldest queued verdict. Covers directed corner texts, random
// well-formed / broken / noise statements in both separator modes and random
// idling on both streams.
// ----------------------------------------------------------------------------
module tb_join_statement_lexer;
  import jsl_pkg::*;

  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = " ";
  localparam logic [7:0] CH_US    = "_";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_FF    = 8'hFF;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // one predicted output transaction: m_tlast plus the packed m_tdata fields
  typedef struct {
    bit      done;
    result_t r;
  } verdict_t;

  // --------------------------------------------------------------------------
  // Scoreboard: local lexer model plus the queue of predicted verdicts
  // --------------------------------------------------------------------------
  class stmt_scoreboard;
    bit          mode;
    phase_t      phase;
    logic [15:0] opnd_cnt;
    bit          has_label;
    status_t     first_err;
    logic [15:0] stmt_no;
    logic [15:0] err_cnt;
    verdict_t    verdicts[$];
    int          fails;
    int          checked;
    int          stmts;
    int          bad_stmts;

    function new();
      mode = 1'b0;
      clear_statement();
      stmt_no = 16'd1;
      err_cnt = '0;
    endfunction

    static function bit splits(logic [7:0] c, bit m);
      return m ? (c == CH_COMMA || c == CH_SEMI) : (c == CH_NL);
    endfunction

    static function bit name_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == CH_US || c == CH_DASH;
    endfunction

    static function bit blank_char(logic [7:0] c);
      return c == CH_SP || c == CH_TAB || c == CH_CR;
    endfunction

    static function logic [15:0] sat_up(logic [15:0] v);
      return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

    function void clear_statement();
      phase     = PH_START;
      opnd_cnt  = '0;
      has_label = 1'b0;
      first_err = ST_BLANK;
    endfunction

    function void raise_error(status_t code);
      first_err = code;
      phase     = PH_ERROR;
    endfunction

    // role of a non-separator byte; moves the parse phase along
    function role_t classify_byte(logic [7:0] c, output bit start);
      phase_t ph;
      ph    = phase;
      start = 1'b0;
      if (ph == PH_COMMENT || ph == PH_ERROR) return ROLE_COMMENT;
      if (ph == PH_OPER || ph == PH_LABEL) begin
        if (name_char(c)) return (ph == PH_OPER) ? ROLE_OPERAND : ROLE_LABEL;
        if (blank_char(c)) begin
          phase = (ph == PH_OPER) ? PH_AFTER_OPER : PH_AFTER_LABEL;
          return ROLE_BLANK;
        end
        // token ends on a non-blank: treat the byte as following the token
        ph = (ph == PH_OPER) ? PH_AFTER_OPER : PH_AFTER_LABEL;
      end
      if (blank_char(c)) return ROLE_BLANK;
      case (ph)
        PH_START, PH_NEED_OPER: begin
          if (name_char(c)) begin
            start    = 1'b1;
            opnd_cnt = sat_up(opnd_cnt);
            phase    = PH_OPER;
            return ROLE_OPERAND;
          end
          // in this branch a comment is only legal where a fresh statement could begin
          if (c == CH_HASH && ph == PH_START) begin
            phase = PH_COMMENT;
            return ROLE_COMMENT;
          end
          raise_error(ST_NAME);
          return ROLE_COMMENT;
        end
        PH_NEED_LABEL: begin
          if (name_char(c)) begin
            start     = 1'b1;
            has_label = 1'b1;
            phase     = PH_LABEL;
            return ROLE_LABEL;
          end
          raise_error(ST_LABEL);
          return ROLE_COMMENT;
        end
        PH_AFTER_OPER: begin
          if (c == CH_PLUS) begin
            phase = PH_NEED_OPER;
            return ROLE_OPER;
          end
          if (c == CH_EQ) begin
            phase = PH_NEED_LABEL;
            return ROLE_OPER;
          end
        end
        default: ;
      endcase
      if (c == CH_HASH) begin
        phase = PH_COMMENT;
        return ROLE_COMMENT;
      end
      raise_error(ST_CHAR);
      return ROLE_COMMENT;
    endfunction

    function status_t close_status();
      case (phase)
        PH_START:      return ST_BLANK;
        PH_NEED_OPER:  return ST_NAME;
        PH_NEED_LABEL: return ST_LABEL;
        PH_COMMENT:    return (opnd_cnt != 0) ? ST_OK : ST_BLANK;
        PH_ERROR:      return first_err;
        default:       return ST_OK;
      endcase
    endfunction

    // input transaction accepted: predict its verdict
    function void note_byte(logic [7:0] c, bit last);
      verdict_t v;
      bit       sep;
      bit       start;
      status_t  st;
      sep   = splits(c, mode);
      start = 1'b0;
      v.done = 1'b0;
      v.r    = '0;
      v.r.role = sep ? ROLE_SEP : classify_byte(c, start);
      v.r.token_start = start;
      if (sep || last) begin
        st = close_status();
        if (st >= ST_NAME) begin
          err_cnt = sat_up(err_cnt);
          bad_stmts++;
        end
        stmts++;
        v.done            = 1'b1;
        v.r.status        = st;
        v.r.operands      = opnd_cnt;
        v.r.label_present = (st == ST_OK) ? has_label : 1'b0;
        v.r.index         = stmt_no;
        v.r.errors        = err_cnt;
        stmt_no = sat_up(stmt_no);
        clear_statement();
        // end of text: numbering and error count start over
        if (last) begin
          stmt_no = 16'd1;
          err_cnt = '0;
        end
      end
      verdicts.push_back(v);
    endfunction

    // output transaction accepted: compare with the oldest prediction
    function void check_verdict(logic [55:0] data, logic done);
      verdict_t want;
      result_t  got;
      got = data;
      checked++;
      if (verdicts.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("[%0t] unexpected verdict: data=%h done=%b", $realtime, data, done);
        return;
      end
      want = verdicts.pop_front();
      if (done !== want.done || got.role !== want.r.role ||
          got.token_start !== want.r.token_start || got.status !== want.r.status ||
          got.operands !== want.r.operands || got.label_present !== want.r.label_present ||
          got.index !== want.r.index || got.errors !== want.r.errors) begin
        fails++;
        if (fails <= 10) begin
          $display("[%0t] verdict mismatch #%0d (done role start status ops label idx errs)",
                   $realtime, fails);
          $display("  exp: %0d %0d %0d %0d %0d %0d %0d %0d", want.done, want.r.role,
                   want.r.token_start, want.r.status, want.r.operands,
                   want.r.label_present, want.r.index, want.r.errors);
          $display("  got: %0d %0d %0d %0d %0d %0d %0d %0d", done, got.role,
                   got.token_start, got.status, got.operands, got.label_present,
                   got.index, got.errors);
        end
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its stimulus signals (all known from time zero)
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data  = '0;

  stmt_scoreboard sb = new();

  bit         src_idle_en  = 1'b1;
  bit         sink_idle_en = 1'b1;
  int         bytes_sent;
  logic [7:0] text_buf[$];

  join_statement_lexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [7:0] char_in
    .s_tlast  (s_tlast),    // last_char
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // role, start, status, ops, label, index, errors
    .m_tlast  (m_tlast),    // statement_done
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // receiver: random back-pressure on the result stream
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = pick_gap();
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  end

  // result monitor: values read here are the ones before the edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_verdict(m_tdata, m_tlast);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One input transaction. Called at a rising edge; returns at the edge where
  // the byte was taken, with tvalid still high for a possible next byte.
  task automatic send_byte(logic [7:0] c, bit last);
    int gap;
    gap = (src_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(c, last);
    bytes_sent++;
  endtask

  task automatic send_text(string s, bit close_text);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close_text && i == s.len() - 1);
  endtask

  // Mode write only once the block has drained; the extra cycles cover the
  // two-stage pipe before the register changes.
  task automatic write_mode(bit m);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.mode = m;
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random statement text
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_name_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 63);
    if (r < 26)      c = 8'("a" + r);
    else if (r < 52) c = 8'("A" + r - 26);
    else if (r < 62) c = 8'("0" + r - 52);
    else if (r == 62) c = CH_US;
    else              c = CH_DASH;
    return c;
  endfunction

  function automatic void add_blanks();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       text_buf.push_back(CH_SP);
        1:       text_buf.push_back(CH_TAB);
        default: text_buf.push_back(CH_CR);
      endcase
    end
  endfunction

  function automatic void add_name();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) text_buf.push_back(rand_name_char());
  endfunction

  // name + name ... [= label] [# comment], random spacing and content
  function automatic void add_body(bit m);
    int         nops;
    int         n;
    logic [7:0] c;
    nops = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    add_blanks();
    for (int i = 0; i < nops; i++) begin
      if (i > 0) begin
        text_buf.push_back(CH_PLUS);
        add_blanks();
      end
      add_name();
      add_blanks();
    end
    if (nops > 0 && $urandom_range(0, 1) == 1) begin
      text_buf.push_back(CH_EQ);
      add_blanks();
      add_name();
      add_blanks();
    end
    if ($urandom_range(0, 3) == 0) begin
      text_buf.push_back(CH_HASH);
      n = $urandom_range(0, 5);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255)); while (stmt_scoreboard::splits(c, m));
        text_buf.push_back(c);
      end
    end
  endfunction

  // 70% well-formed, 10% broken, 20% raw noise; about one in eight closes
  // the text, with tlast either on a separator or on the final plain byte
  task automatic send_statement(bit m);
    int  kind;
    int  n;
    bit  close_text;
    text_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      n = $urandom_range(1, 6);
      repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_body(m);
      if (kind == 7) begin
        case ($urandom_range(0, 2))
          0: text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_EQ);
          1: if (text_buf.size() > 0)
               text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
          default: text_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    close_text = ($urandom_range(0, 7) == 0);
    if (!close_text || text_buf.size() == 0 || $urandom_range(0, 1) == 1)
      text_buf.push_back(m ? ($urandom_range(0, 1) ? CH_COMMA : CH_SEMI) : CH_NL);
    for (int i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], close_text && i == text_buf.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int base;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, newline mode: label + comment with a high byte, a NUL where
    // a name belongs, dangling '+', foreign ';', last byte closing on '='
    write_mode(1'b0);
    send_text("x+Y=z\t#", 1'b0);
    send_byte(CH_FF, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_text("a+\n", 1'b0);
    send_text("9;\n", 1'b0);
    send_text("-_ =", 1'b1);

    // directed, comma mode: blank statement, newline as plain byte, last on
    // a separator closes only once
    write_mode(1'b1);
    send_text(" ,b\n, ;", 1'b1);

    // random phases, alternating the separator mode
    for (int p = 0; p < 3; p++) begin
      write_mode(p[0] ? 1'b0 : 1'b1);
      base = bytes_sent;
      while (bytes_sent - base < 120) send_statement(p[0] ? 1'b0 : 1'b1);
    end

    // drain, then a few quiet cycles to catch stray transactions
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d bytes, %0d statements (%0d with syntax errors), %0d verdicts",
             bytes_sent, sb.stmts, sb.bad_stmts, sb.checked);
    $display("in both separator modes with random idling on both streams; %0d mismatches",
             sb.fails);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
